[src/ssc_pkg.sv]
// Shared types and constants of the shadow stack monitor.
// No dependencies; ssc_stack, ssc_jop, the top level and the testbench import this package.
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int unsigned STACK_DEPTH = 2048;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned LEVEL_W     = 12;
  localparam int unsigned RUN_W       = 16;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned TOTAL_W     = 32;

  localparam logic [RUN_W-1:0] RUN_LIMIT_RST  = RUN_W'(600);
  localparam logic [LEN_W-1:0] GADGET_MAX_RST = LEN_W'(8);
  localparam logic [LEN_W-1:0] CHAIN_MIN_RST  = LEN_W'(24);

  // register indexes on the configuration port (byte address / 4)
  localparam logic [1:0] REG_RUN_LIMIT  = 2'd0;
  localparam logic [1:0] REG_GADGET_MAX = 2'd1;
  localparam logic [1:0] REG_CHAIN_MIN  = 2'd2;

  typedef enum logic [1:0] {
    OP_OTHER = 2'd0,
    OP_CALL  = 2'd1,
    OP_RET   = 2'd2,
    OP_JUMP  = 2'd3
  } op_e;

  typedef struct packed {
    logic             ret_valid;
    logic             ret_violation;
    logic             run_exceeded;
    logic             push_overflow;
    logic [CNT_W-1:0] level;
  } stk_res_t;

  typedef struct packed {
    logic               alert;
    logic [TOTAL_W-1:0] total;
  } jop_res_t;

endpackage

[src/ssc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ssc_stack.sv]
// Shadow stack controller: push on call, pop-and-compare unwinding on return.
// Depends on ssc_pkg and ssc_ram.
`timescale 1ns / 1ps

module ssc_stack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  ssc_pkg::op_e                  op_i,
  input  logic [ssc_pkg::ADDR_W-1:0]    addr_i,
  input  logic [ssc_pkg::RUN_W-1:0]     run_limit_i,
  input  logic                          take_i,
  output logic                          ready_o,
  output logic                          res_valid_o,
  output ssc_pkg::stk_res_t             res_o
);

  import ssc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [STACK_AW-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [RUN_W-1:0]  run_q, run_d;
  stk_res_t          res_q, res_d;

  logic [CNT_W-1:0]    count_m1;
  logic [STACK_AW-1:0] ptr_m1;
  logic [RUN_W-1:0]    run_inc;
  logic                ram_we;
  logic [STACK_AW-1:0] ram_raddr;
  logic [ADDR_W-1:0]   ram_rdata;

  assign count_m1 = count_q - CNT_W'(1);
  assign ptr_m1   = ptr_q - STACK_AW'(1);
  assign run_inc  = (run_q != '1) ? run_q + RUN_W'(1) : run_q;

  // A call writes its entry in the accept cycle; the earliest read of it that is used
  // comes in the accept cycle of a later return, so no forwarding is needed.
  assign ram_we    = start_i && (state_q == ST_IDLE) && (op_i == OP_CALL) &&
                     (count_q < CNT_W'(STACK_DEPTH));
  // Read ahead: the next entry below is fetched while the current one is compared.
  assign ram_raddr = (state_q == ST_IDLE) ? count_m1[STACK_AW-1:0] : ptr_m1;

  ssc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[STACK_AW-1:0]),
    .wdata_i (addr_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    addr_d  = addr_q;
    run_d   = run_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          addr_d    = addr_i;
          res_d     = '0;
          res_d.level = count_q;
          state_d   = ST_DONE;
          unique case (op_i)
            OP_CALL: begin
              run_d = '0;
              if (count_q >= CNT_W'(STACK_DEPTH)) begin
                res_d.push_overflow = 1'b1;
              end else begin
                count_d     = count_q + CNT_W'(1);
                res_d.level = count_q + CNT_W'(1);
              end
            end
            OP_RET: begin
              if (count_q == '0) begin
                res_d.ret_violation = 1'b1;
              end else begin
                ptr_d   = count_m1[STACK_AW-1:0];
                state_d = ST_POP;
              end
            end
            OP_OTHER, OP_JUMP: ;
          endcase
        end
      end
      ST_POP: begin
        if (ram_rdata == addr_q) begin
          count_d            = CNT_W'(ptr_q);
          run_d              = run_inc;
          res_d.ret_valid    = 1'b1;
          res_d.run_exceeded = (run_inc > run_limit_i);
          res_d.level        = CNT_W'(ptr_q);
          state_d            = ST_DONE;
        end else if (ptr_q == '0) begin
          count_d             = '0;
          res_d.ret_violation = 1'b1;
          res_d.level         = '0;
          state_d             = ST_DONE;
        end else begin
          ptr_d = ptr_m1;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      run_q   <= '0;
      ptr_q   <= '0;
      addr_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      run_q   <= run_d;
      ptr_q   <= ptr_d;
      addr_q  <= addr_d;
      res_q   <= res_d;
    end
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

[src/ssc_jop.sv]
// Jump-oriented chain tracker: gadget length count, short-jump run, alert total.
// Depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_jop (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  ssc_pkg::op_e              op_i,
  input  logic [ssc_pkg::LEN_W-1:0] gadget_max_i,
  input  logic [ssc_pkg::LEN_W-1:0] chain_min_i,
  output ssc_pkg::jop_res_t         res_o
);

  import ssc_pkg::*;

  logic [LEN_W-1:0]   instr_q, instr_d;
  logic [LEN_W-1:0]   chain_q, chain_d;
  logic               alert_q, alert_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic [LEN_W-1:0] instr_inc;
  logic [LEN_W-1:0] chain_grow;

  assign instr_inc = (instr_q != '1) ? instr_q + LEN_W'(1) : instr_q;

  always_comb begin
    instr_d    = instr_q;
    chain_d    = chain_q;
    alert_d    = alert_q;
    total_d    = total_q;
    chain_grow = '0;
    if (start_i) begin
      alert_d = 1'b0;
      if (op_i == OP_JUMP) begin
        instr_d = '0;
        if (instr_inc <= gadget_max_i) begin
          chain_grow = (chain_q != '1) ? chain_q + LEN_W'(1) : chain_q;
        end
        chain_d = chain_grow;
        // restart the chain after each alert
        if (chain_grow >= chain_min_i) begin
          alert_d = 1'b1;
          chain_d = '0;
          if (total_q != '1) begin
            total_d = total_q + TOTAL_W'(1);
          end
        end
      end else begin
        instr_d = instr_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      instr_q <= '0;
      chain_q <= '0;
      alert_q <= 1'b0;
      total_q <= '0;
    end else begin
      instr_q <= instr_d;
      chain_q <= chain_d;
      alert_q <= alert_d;
      total_q <= total_d;
    end
  end

  assign res_o.alert = alert_q;
  assign res_o.total = total_q;

endmodule

[src/shadow_stack_cfi_monitor_core.sv]
// Top level of the shadow stack monitor: stream ports, config registers, output word.
// Depends on ssc_pkg, ssc_stack and ssc_jop.
`timescale 1ns / 1ps

// One result word per accepted instruction word. Other, call and jump words pass
// through the accept cycle and the result state, in which the result moves into the
// output register. A return also visits a pop state for each shadow stack entry
// examined (one read per cycle on the stack memory's single read port, the last
// one being the match or the bottom of the stack); a return on an empty stack goes
// straight to the result state. The next word is taken while a result still waits
// in the output register. The stack memory needs no clearing after reset.
module shadow_stack_cfi_monitor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] address
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] return_valid, [1] return_violation, [2] return_run_exceeded,
  // [3] push_overflow, [4] jop_alert, [36:5] jop_total, [48:37] stack_level,
  // [55:49] zero
  output logic [55:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ssc_pkg::*;

  logic [RUN_W-1:0] run_limit_q;
  logic [LEN_W-1:0] gadget_max_q;
  logic [LEN_W-1:0] chain_min_q;
  logic             cfg_we;

  logic       accept;
  op_e        op;
  logic       stk_ready;
  logic       stk_res_valid;
  stk_res_t   stk_res;
  jop_res_t   jop_res;
  logic       take;

  logic        out_valid_q, out_valid_d;
  logic [55:0] out_data_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_limit_q  <= RUN_LIMIT_RST;
      gadget_max_q <= GADGET_MAX_RST;
      chain_min_q  <= CHAIN_MIN_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_RUN_LIMIT:  run_limit_q  <= pwdata[RUN_W-1:0];
        REG_GADGET_MAX: gadget_max_q <= pwdata[LEN_W-1:0];
        REG_CHAIN_MIN:  chain_min_q  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RUN_LIMIT:  prdata = 32'(run_limit_q);
      REG_GADGET_MAX: prdata = 32'(gadget_max_q);
      REG_CHAIN_MIN:  prdata = 32'(chain_min_q);
      default:        prdata = '0;
    endcase
  end

  // input side
  assign op            = op_e'(s_axis_tuser);
  assign s_axis_tready = stk_ready;
  assign accept        = s_axis_tvalid && stk_ready;

  ssc_stack u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .op_i        (op),
    .addr_i      (s_axis_tdata),
    .run_limit_i (run_limit_q),
    .take_i      (take),
    .ready_o     (stk_ready),
    .res_valid_o (stk_res_valid),
    .res_o       (stk_res)
  );

  ssc_jop u_jop (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .op_i         (op),
    .gadget_max_i (gadget_max_q),
    .chain_min_i  (chain_min_q),
    .res_o        (jop_res)
  );

  // output register: load the finished result when the slot is free or draining
  assign take        = stk_res_valid && (!out_valid_q || m_axis_tready);
  assign out_valid_d = take ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= {7'd0, LEVEL_W'(stk_res.level), jop_res.total, jop_res.alert,
                     stk_res.push_overflow, stk_res.run_exceeded,
                     stk_res.ret_violation, stk_res.ret_valid};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_res_valid |-> (stk_res.level <= CNT_W'(STACK_DEPTH)))
    else $error("stack level beyond depth");

  a_violation_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stk_res_valid && stk_res.ret_violation) |-> (stk_res.level == '0))
    else $error("violation left entries on the stack");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_res_valid |-> $onehot0({stk_res.ret_valid, stk_res.ret_violation,
                                stk_res.push_overflow, jop_res.alert}))
    else $error("result flags of different classes together");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("word taken while the previous one is in flight");

endmodule

[tb/testbench.sv]
// Self-checking bench for shadow_stack_cfi_monitor_core: a scoreboard class predicts each
// result word from the accepted instruction words; plain tasks drive stream and APB ports.
// Depends on ssc_pkg and the RTL under src.
`timescale 1ns / 1ps

module testbench;
  import ssc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 4;

  // result word as laid out on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [6:0]         pad;
    logic [LEVEL_W-1:0] level;
    logic [TOTAL_W-1:0] total;
    logic               alert;
    logic               overflow;
    logic               run_over;
    logic               violation;
    logic               matched;
  } cfi_word_t;

  class cfi_scoreboard;
    logic [ADDR_W-1:0]  entries [STACK_DEPTH];
    int unsigned        level;
    int unsigned        ret_run;
    int unsigned        since_jump;
    int unsigned        short_run;
    logic [TOTAL_W-1:0] alert_count;
    logic [RUN_W-1:0]   run_limit;
    logic [LEN_W-1:0]   gadget_len;
    logic [LEN_W-1:0]   chain_len;
    cfi_word_t          pending[$];
    int                 errors;
    int                 checked;

    function new();
      level       = 0;
      ret_run     = 0;
      since_jump  = 0;
      short_run   = 0;
      alert_count = '0;
      run_limit   = RUN_LIMIT_RST;
      gadget_len  = GADGET_MAX_RST;
      chain_len   = CHAIN_MIN_RST;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_RUN_LIMIT:  run_limit  = value[RUN_W-1:0];
        REG_GADGET_MAX: gadget_len = value[LEN_W-1:0];
        REG_CHAIN_MIN:  chain_len  = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the predicted monitor state by one instruction word
    function void note_input(op_e op, logic [ADDR_W-1:0] addr);
      cfi_word_t w;
      bit        found;
      w = '0;
      found = 0;
      if (since_jump < 255) since_jump++;
      case (op)
        OP_CALL: begin
          ret_run = 0;
          if (level >= STACK_DEPTH) begin
            w.overflow = 1'b1;
          end else begin
            entries[level] = addr;
            level++;
          end
        end
        OP_RET: begin
          // unwind until the target matches or the stack runs dry
          while (level > 0 && !found) begin
            level--;
            if (entries[level] == addr) found = 1;
          end
          if (found) begin
            w.matched = 1'b1;
            if (ret_run < 65535) ret_run++;
            if (ret_run > run_limit) w.run_over = 1'b1;
          end else begin
            w.violation = 1'b1;
          end
        end
        OP_JUMP: begin
          if (since_jump <= gadget_len) begin
            if (short_run < 255) short_run++;
          end else begin
            short_run = 0;
          end
          since_jump = 0;
          if (short_run >= chain_len) begin
            w.alert = 1'b1;
            short_run = 0;
            if (alert_count != '1) alert_count++;
          end
        end
        default: ;
      endcase
      w.total = alert_count;
      w.level = LEVEL_W'(level);
      pending.push_back(w);
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t ns MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      errors++;
    endtask

    task check_result(logic [55:0] word);
      cfi_word_t got;
      cfi_word_t want;
      got = word;
      if (pending.size() == 0) begin
        report("result word with nothing outstanding", '0, word);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.matched   !== want.matched)   report("return_valid", want.matched, got.matched);
      if (got.violation !== want.violation)
        report("return_violation", want.violation, got.violation);
      if (got.run_over  !== want.run_over)
        report("return_run_exceeded", want.run_over, got.run_over);
      if (got.overflow  !== want.overflow)  report("push_overflow", want.overflow, got.overflow);
      if (got.alert     !== want.alert)     report("jop_alert", want.alert, got.alert);
      if (got.total     !== want.total)     report("jop_total", want.total, got.total);
      if (got.level     !== want.level)     report("stack_level", want.level, got.level);
      if (got.pad       !== want.pad)       report("padding bits", want.pad, got.pad);
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = OP_OTHER;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  cfi_scoreboard sb = new();
  bit            gaps_on   = 1'b1;
  int            hold_left = 0;
  int            words_sent = 0;
  int            settings_used = 0;
  int unsigned   quiet_cycles = 0;

  int unsigned lim_tab [6] = '{600, 0, 65534, 3, 2, 1};
  int unsigned gad_tab [6] = '{8, 254, 0, 4, 8, 2};
  int unsigned chn_tab [6] = '{24, 1, 255, 3, 0, 2};

  shadow_stack_cfi_monitor_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // receiver: random stalls plus a long hold-off when hold_left is set
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 14);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no word moved for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly a live entry near the top, sometimes deep, sometimes a stray target
  function automatic logic [63:0] return_target();
    int unsigned off;
    if (sb.level == 0 || $urandom_range(0, 99) < 20) return rand64();
    if ($urandom_range(0, 99) < 70)
      off = 0;
    else if ($urandom_range(0, 1) == 1)
      off = $urandom_range(0, (sb.level > 6) ? 5 : sb.level - 1);
    else
      off = $urandom_range(0, sb.level - 1);
    return sb.entries[sb.level - 1 - off];
  endfunction

  function automatic logic [63:0] top_target();
    if (sb.level == 0) return rand64();
    return sb.entries[sb.level - 1];
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(op_e op, logic [63:0] addr);
    while (gaps_on && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= addr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, addr);
    words_sent++;
    @(negedge clk_i);
  endtask

  // drop valid and hold until every outstanding result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] back;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    back = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    // leave the bus idle before the next transfer
    @(negedge clk_i);
    if (back !== value) sb.report($sformatf("readback of register %0d", idx), value, back);
  endtask

  task automatic apply_setting(int unsigned lim, int unsigned gad, int unsigned chn);
    write_reg(REG_RUN_LIMIT, lim);
    write_reg(REG_GADGET_MAX, gad);
    write_reg(REG_CHAIN_MIN, chn);
    settings_used++;
  endtask

  task automatic run_random(int target);
    int n;
    int m;
    int k;
    int gap;
    op_e op;
    n = 0;
    while (n < target) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // chain of jumps with short gaps
          m   = $urandom_range(1, 30);
          gap = $urandom_range(0, 6);
          repeat (m) begin
            k = $urandom_range(0, gap);
            repeat (k) begin
              send_word(OP_OTHER, rand64());
              n++;
            end
            send_word(OP_JUMP, rand64());
            n++;
          end
        end
        2, 3: begin
          // balanced call nest, unwound in order
          m = $urandom_range(1, 8);
          repeat (m) begin
            send_word(OP_CALL, rand64());
            n++;
            if ($urandom_range(0, 3) == 0) begin
              send_word(OP_OTHER, rand64());
              n++;
            end
          end
          repeat (m) begin
            send_word(OP_RET, top_target());
            n++;
          end
        end
        default: begin
          op = op_e'($urandom_range(0, 3));
          send_word(op, (op == OP_RET) ? return_target() : rand64());
          n++;
        end
      endcase
    end
  endtask

  // fill the stack past its depth, then unwind it from the bottom entry
  task automatic fill_stack();
    repeat (STACK_DEPTH + 3) send_word(OP_CALL, {$urandom, $urandom});
    send_word(OP_RET, sb.entries[0]);
    send_word(OP_RET, rand64());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words under reset register values
    send_word(OP_RET,   64'h0000_0000_0040_1000);  // empty stack
    send_word(OP_OTHER, '1);
    send_word(OP_CALL,  '0);
    send_word(OP_CALL,  '1);
    send_word(OP_RET,   '1);
    send_word(OP_RET,   '0);
    send_word(OP_CALL,  64'h0000_7fff_0000_1110);
    send_word(OP_CALL,  64'h0000_7fff_0000_2220);
    send_word(OP_RET,   64'h0000_7fff_0000_3330);  // no match: unwind all
    send_word(OP_CALL,  64'hdead_0000_0000_0a00);
    send_word(OP_CALL,  64'hdead_0000_0000_0b00);
    send_word(OP_CALL,  64'hdead_0000_0000_0a00);
    send_word(OP_RET,   64'hdead_0000_0000_0a00);  // topmost duplicate only
    send_word(OP_RET,   64'hdead_0000_0000_0a00);
    send_word(OP_CALL,  64'h8000_0000_0000_0010);
    send_word(OP_CALL,  64'h8000_0000_0000_0020);
    send_word(OP_CALL,  64'h8000_0000_0000_0030);
    send_word(OP_RET,   64'h8000_0000_0000_0010);  // deep match
    send_word(OP_JUMP,  '0);
    send_word(OP_JUMP,  '1);
    send_word(OP_OTHER, 64'h5555_aaaa_5555_aaaa);
    send_word(OP_JUMP,  64'haaaa_5555_aaaa_5555);

    for (int p = 0; p < 6; p++) begin
      drain();
      apply_setting(lim_tab[p], gad_tab[p], chn_tab[p]);
      case (p)
        1: begin
          // saturate the instruction count, then take a long jump
          repeat (260) send_word(OP_OTHER, rand64());
          send_word(OP_JUMP, rand64());
          run_random(100);
        end
        2: begin
          gaps_on = 1'b0;
          fill_stack();
          run_random(100);
          gaps_on = 1'b1;
        end
        3: begin
          run_random(50);
          hold_left = 300;
          run_random(50);
        end
        5: begin
          run_random(50);
          drain();
          run_random(50);
        end
        default: run_random(100);
      endcase
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Summary: %0d instruction words sent, %0d result words checked, %0d settings",
             words_sent, sb.checked, settings_used);
    $display("Summary: stack filled past depth %0d, unwinds, gadget chains and run limits hit",
             STACK_DEPTH);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
